/* rtl/epct_pkg.sv */
`default_nettype none
package epct_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned KeyWidth   = 64;
  localparam int unsigned CountWidth = 64;
  localparam int unsigned DistWidth  = 11;
  localparam int unsigned HashMult   = 7;

  localparam int unsigned DefTableEntries = 1024;
  localparam int unsigned DefProbeLimit   = 8;

  localparam int unsigned QueueDepth = 2;

  // func field codes
  localparam logic FuncRecord = 1'b0;
  localparam logic FuncClear  = 1'b1;

endpackage
`default_nettype wire

/* rtl/edge_pair_count_table_core.sv */
// Flow: a record is hashed when accepted; the front then finds its home slot in its
//   multiply and reduce steps and pushes it to the queue, and the back reads and checks
//   each probed slot in turn until one decides. A clear skips the hash steps.
// The front takes no new transaction until it has pushed the last one to the queue;
//   runs of probes in the back can fill the queue and so hold the input as well.
// After its result, a clear sweeps every entry of the table memory.
// Reset: async active low; a clearing pass over every table entry follows, input stalled.
`default_nettype none
module edge_pair_count_table_core #(
  parameter int unsigned TABLE_ENTRIES = epct_pkg::DefTableEntries,
  parameter int unsigned PROBE_LIMIT   = epct_pkg::DefProbeLimit
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             func_i,
  input  wire logic [epct_pkg::AddrWidth-1:0]   exec_address_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [epct_pkg::CountWidth-1:0]       edge_count_o,
  output logic                                  new_edge_o,
  output logic                                  table_full_o,
  output logic [epct_pkg::DistWidth-1:0]        distinct_edges_o,
  output logic [epct_pkg::CountWidth-1:0]       total_events_o
);

  localparam int unsigned IdxWidth = $clog2(TABLE_ENTRIES);
  localparam int unsigned QWidth   = 1 + epct_pkg::KeyWidth + IdxWidth;

  logic              init_busy;
  logic              q_full;
  logic              q_push;
  logic [QWidth-1:0] q_wdata;
  logic              q_empty;
  logic              q_pop;
  logic [QWidth-1:0] q_rdata;

  epct_front #(
    .TableEntries(TABLE_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .exec_address_i(exec_address_i),
    .hold_i        (init_busy),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  epct_queue #(
    .Width(QWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  epct_back #(
    .TableEntries(TABLE_ENTRIES),
    .ProbeLimit  (PROBE_LIMIT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .init_busy_o     (init_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .edge_count_o    (edge_count_o),
    .new_edge_o      (new_edge_o),
    .table_full_o    (table_full_o),
    .distinct_edges_o(distinct_edges_o),
    .total_events_o  (total_events_o)
  );

endmodule
`default_nettype wire

/* rtl/epct_front.sv */
`default_nettype none
module epct_front #(
  parameter int unsigned TableEntries = epct_pkg::DefTableEntries,
  localparam int unsigned IdxWidth = $clog2(TableEntries),
  localparam int unsigned QWidth = 1 + epct_pkg::KeyWidth + IdxWidth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic [epct_pkg::AddrWidth-1:0]     exec_address_i,
  input  wire logic                               hold_i,
  input  wire logic                               q_full_i,
  output logic                                    q_push_o,
  output logic [QWidth-1:0]                       q_data_o
);

  localparam logic [IdxWidth:0] Modulus = (IdxWidth+1)'(TableEntries);
  // reciprocal of the table size; the quotient estimate is low by at most one
  localparam int unsigned Shift = epct_pkg::AddrWidth - 1 + IdxWidth;
  localparam logic [63:0] RecipWide = (64'd1 << Shift) / 64'(TableEntries);
  localparam logic [epct_pkg::AddrWidth-1:0] Recip = RecipWide[epct_pkg::AddrWidth-1:0];

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_RED,
    F_PUSH
  } front_state_e;

  front_state_e                      state_q;
  logic [epct_pkg::AddrWidth-1:0]    prev_q;
  logic [epct_pkg::AddrWidth-1:0]    hash_q;
  logic [epct_pkg::AddrWidth-1:0]    quot_q;
  logic [IdxWidth:0]                 diff_q;
  logic [63:0]                       prod;
  logic [epct_pkg::AddrWidth-1:0]    diff;
  logic [IdxWidth-1:0]               home;
  logic [epct_pkg::KeyWidth-1:0]     key_q;
  logic                              func_q;
  logic                              accept;

  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o   = {func_q, key_q, home};

  assign prod = 64'(hash_q) * 64'(Recip);
  assign diff = hash_q - epct_pkg::AddrWidth'(quot_q * epct_pkg::AddrWidth'(TableEntries));
  assign home = (diff_q >= Modulus) ? IdxWidth'(diff_q - Modulus) : diff_q[IdxWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      prev_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            if (func_i == epct_pkg::FuncClear) begin
              state_q <= F_PUSH;
            end else begin
              prev_q  <= exec_address_i;
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          state_q <= F_RED;
        end
        F_RED: begin
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= {prev_q, exec_address_i};
      hash_q <= epct_pkg::AddrWidth'(exec_address_i * epct_pkg::AddrWidth'(epct_pkg::HashMult))
                + prev_q;
    end
    if (state_q == F_MUL) begin
      quot_q <= epct_pkg::AddrWidth'(prod >> Shift);
    end
    if (state_q == F_RED) begin
      diff_q <= diff[IdxWidth:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/epct_queue.sv */
`default_nettype none
module epct_queue #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned Depth    = epct_pkg::QueueDepth;
  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    entries_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q;
  logic [PtrWidth-1:0] rd_ptr_q;
  logic [CntWidth-1:0] count_q;
  logic                do_push;
  logic                do_pop;

  assign full_o  = count_q == CntWidth'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/epct_back.sv */
`default_nettype none
module epct_back #(
  parameter int unsigned TableEntries = epct_pkg::DefTableEntries,
  parameter int unsigned ProbeLimit   = epct_pkg::DefProbeLimit,
  localparam int unsigned IdxWidth = $clog2(TableEntries),
  localparam int unsigned QWidth = 1 + epct_pkg::KeyWidth + IdxWidth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_empty_i,
  input  wire logic [QWidth-1:0]                q_data_i,
  output logic                                  q_pop_o,
  output logic                                  init_busy_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [epct_pkg::CountWidth-1:0]       edge_count_o,
  output logic                                  new_edge_o,
  output logic                                  table_full_o,
  output logic [epct_pkg::DistWidth-1:0]        distinct_edges_o,
  output logic [epct_pkg::CountWidth-1:0]       total_events_o
);

  localparam int unsigned KW        = epct_pkg::KeyWidth;
  localparam int unsigned CW        = epct_pkg::CountWidth;
  localparam int unsigned EntWidth  = 1 + KW + CW;
  localparam int unsigned ProbeWidth = $clog2(ProbeLimit + 1);
  localparam int unsigned EdgeWidth = $clog2(TableEntries + 1);

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_RD,
    B_CHK,
    B_CLR,
    B_SWEEP
  } back_state_e;

  back_state_e                  state_q;
  logic [IdxWidth-1:0]          idx_q;
  logic [IdxWidth-1:0]          idx_next;
  logic [ProbeWidth-1:0]        probe_q;
  logic [KW-1:0]                key_q;
  logic [EdgeWidth-1:0]         edge_total_q;
  logic [EdgeWidth-1:0]         edge_total_new;
  logic [CW-1:0]                event_total_q;
  logic [EdgeWidth+epct_pkg::DistWidth-1:0] dist_ext;

  logic [EntWidth-1:0]          mem [TableEntries];
  logic [EntWidth-1:0]          rd_data_q;
  logic [EntWidth-1:0]          mem_wdata;
  logic                         mem_we;
  logic                         mem_re;

  logic                         rd_valid;
  logic [KW-1:0]                rd_key;
  logic [CW-1:0]                rd_count;
  logic                         hit;
  logic                         miss;
  logic                         last_probe;
  logic                         out_free;
  logic                         sweeping;

  logic                         out_valid_q;
  logic [CW-1:0]                edge_count_q;
  logic                         new_edge_q;
  logic                         table_full_q;
  logic [epct_pkg::DistWidth-1:0] distinct_q;
  logic [CW-1:0]                total_events_q;

  assign rd_valid   = rd_data_q[EntWidth-1];
  assign rd_key     = rd_data_q[EntWidth-2 -: KW];
  assign rd_count   = rd_data_q[CW-1:0];
  assign hit        = rd_valid && (rd_key == key_q);
  assign miss       = !rd_valid;
  assign last_probe = probe_q == ProbeWidth'(ProbeLimit - 1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sweeping   = (state_q == B_INIT) || (state_q == B_SWEEP);
  assign idx_next   = (idx_q == IdxWidth'(TableEntries - 1)) ? '0 : idx_q + 1'b1;

  assign edge_total_new = edge_total_q + EdgeWidth'(miss);
  assign dist_ext       = {{epct_pkg::DistWidth{1'b0}}, edge_total_new};

  assign q_pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign init_busy_o = state_q == B_INIT;
  assign mem_re      = state_q == B_RD;
  assign mem_we      = sweeping || ((state_q == B_CHK) && out_free && (hit || miss));
  assign mem_wdata   = sweeping ? '0
                     : {1'b1, key_q, hit ? rd_count + 1'b1 : CW'(1)};

  assign out_valid_o      = out_valid_q;
  assign edge_count_o     = edge_count_q;
  assign new_edge_o       = new_edge_q;
  assign table_full_o     = table_full_q;
  assign distinct_edges_o = distinct_q;
  assign total_events_o   = total_events_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_INIT;
      idx_q          <= '0;
      probe_q        <= '0;
      key_q          <= '0;
      edge_total_q   <= '0;
      event_total_q  <= '0;
      out_valid_q    <= 1'b0;
      edge_count_q   <= '0;
      new_edge_q     <= 1'b0;
      table_full_q   <= 1'b0;
      distinct_q     <= '0;
      total_events_q <= '0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_INIT, B_SWEEP: begin
          idx_q <= idx_next;
          if (idx_q == IdxWidth'(TableEntries - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty_i) begin
            key_q   <= q_data_i[QWidth-2 -: KW];
            idx_q   <= q_data_i[IdxWidth-1:0];
            probe_q <= '0;
            state_q <= (q_data_i[QWidth-1] == epct_pkg::FuncClear) ? B_CLR : B_RD;
          end
        end
        B_CLR: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            edge_count_q   <= '0;
            new_edge_q     <= 1'b0;
            table_full_q   <= 1'b0;
            distinct_q     <= '0;
            total_events_q <= '0;
            edge_total_q   <= '0;
            event_total_q  <= '0;
            idx_q          <= '0;
            state_q        <= B_SWEEP;
          end
        end
        B_RD: begin
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (hit || miss || last_probe) begin
            if (out_free) begin
              out_valid_q    <= 1'b1;
              edge_count_q   <= hit ? rd_count + 1'b1 : (miss ? CW'(1) : '0);
              new_edge_q     <= miss;
              table_full_q   <= !hit && !miss;
              distinct_q     <= dist_ext[epct_pkg::DistWidth-1:0];
              total_events_q <= event_total_q + 1'b1;
              edge_total_q   <= edge_total_new;
              event_total_q  <= event_total_q + 1'b1;
              state_q        <= B_IDLE;
            end
          end else begin
            probe_q <= probe_q + 1'b1;
            idx_q   <= idx_next;
            state_q <= B_RD;
          end
        end
        default: state_q <= B_INIT;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/epct_checker.sv */
`default_nettype none
module epct_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [epct_pkg::CountWidth-1:0]  edge_count_o,
  input wire logic                             new_edge_o,
  input wire logic                             table_full_o,
  input wire logic [epct_pkg::DistWidth-1:0]   distinct_edges_o,
  input wire logic [epct_pkg::CountWidth-1:0]  total_events_o
);

  // stalled result transaction stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_count_o)
      && $stable(new_edge_o) && $stable(table_full_o)
      && $stable(distinct_edges_o) && $stable(total_events_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(new_edge_o && table_full_o))
    else $error("edge both inserted and dropped");

  // an inserted edge starts at one and adds to the distinct count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_edge_o |-> edge_count_o == 64'd1 && distinct_edges_o != 11'd0
      && total_events_o != 64'd0)
    else $error("bad result for inserted edge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> edge_count_o == 64'd0 && total_events_o != 64'd0)
    else $error("dropped edge reports a count");

endmodule

bind edge_pair_count_table_core epct_checker u_epct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .edge_count_o    (edge_count_o),
  .new_edge_o      (new_edge_o),
  .table_full_o    (table_full_o),
  .distinct_edges_o(distinct_edges_o),
  .total_events_o  (total_events_o)
);
`default_nettype wire

/* tb/sv/tb_edge_pair_count_table_core.sv */
`timescale 1ns / 100ps
module tb_edge_pair_count_table_core;

  localparam int unsigned AddrWidth    = epct_pkg::AddrWidth;
  localparam int unsigned KeyWidth     = epct_pkg::KeyWidth;
  localparam int unsigned CountWidth   = epct_pkg::CountWidth;
  localparam int unsigned DistWidth    = epct_pkg::DistWidth;
  localparam int unsigned HashMult     = epct_pkg::HashMult;
  localparam int unsigned TableEntries = epct_pkg::DefTableEntries;
  localparam int unsigned ProbeLimit   = epct_pkg::DefProbeLimit;
  // 7 * 439 = 1 mod 1024: solves a hash home for the next address
  localparam int unsigned InvHashMult  = 439;
  localparam int unsigned TotalItems   = 1700;
  localparam int unsigned CalmAfter    = 1550;

  typedef struct packed {
    logic [CountWidth-1:0] edge_count;
    logic                  new_edge;
    logic                  table_full;
    logic [DistWidth-1:0]  distinct_edges;
    logic [CountWidth-1:0] total_events;
  } edge_result_t;

  class edge_profile_scoreboard;
    bit                    slot_used [TableEntries];
    logic [KeyWidth-1:0]   slot_edge [TableEntries];
    logic [CountWidth-1:0] slot_hits [TableEntries];
    logic [AddrWidth-1:0]  last_address;
    logic [DistWidth-1:0]  edges_held;
    logic [CountWidth-1:0] events_seen;
    edge_result_t          pending_q[$];
    int unsigned           error_count;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      last_address = '0;
      edges_held   = '0;
      events_seen  = '0;
      error_count  = 0;
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    // updates the edge table for one accepted transaction and queues its result
    function void note_input(logic func, logic [AddrWidth-1:0] addr);
      edge_result_t         res;
      logic [KeyWidth-1:0]  edge_key;
      logic [AddrWidth-1:0] hash;
      int unsigned          home;
      int unsigned          idx;
      res = '0;
      if (func == epct_pkg::FuncClear) begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        edges_held  = '0;
        events_seen = '0;
      end else begin
        edge_key = {last_address, addr};
        hash = addr * AddrWidth'(HashMult) + last_address;
        home = hash % TableEntries;
        res.table_full = 1'b1;
        for (int p = 0; p < ProbeLimit; p++) begin
          idx = (home + p) % TableEntries;
          if (!slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_edge[idx] = edge_key;
            slot_hits[idx] = 1;
            edges_held++;
            res.edge_count = 1;
            res.new_edge   = 1'b1;
            res.table_full = 1'b0;
            break;
          end else if (slot_edge[idx] == edge_key) begin
            slot_hits[idx]++;
            res.edge_count = slot_hits[idx];
            res.table_full = 1'b0;
            break;
          end
        end
        last_address = addr;
        events_seen++;
      end
      res.distinct_edges = edges_held;
      res.total_events   = events_seen;
      pending_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0d, got %0d", field, expected, actual);
        error_count++;
      end
    endfunction

    function void check_result(edge_result_t got);
      edge_result_t exp_res;
      if (pending_q.size() == 0) begin
        $error("result transaction with none pending: edge_count %0d, total_events %0d",
               got.edge_count, got.total_events);
        error_count++;
        return;
      end
      exp_res = pending_q.pop_front();
      compare_field("edge_count", exp_res.edge_count, got.edge_count);
      compare_field("new_edge", exp_res.new_edge, got.new_edge);
      compare_field("table_full", exp_res.table_full, got.table_full);
      compare_field("distinct_edges", exp_res.distinct_edges, got.distinct_edges);
      compare_field("total_events", exp_res.total_events, got.total_events);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  func_i         = epct_pkg::FuncRecord;
  logic [AddrWidth-1:0]  exec_address_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [CountWidth-1:0] edge_count_o;
  logic                  new_edge_o;
  logic                  table_full_o;
  logic [DistWidth-1:0]  distinct_edges_o;
  logic [CountWidth-1:0] total_events_o;

  edge_profile_scoreboard ledger;
  logic [AddrWidth-1:0]   stim_prev   = '0;
  int unsigned            items_sent  = 0;
  int unsigned            hold_cycles = 0;
  bit                     calm        = 1'b0;

  edge_pair_count_table_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .exec_address_i   (exec_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .edge_count_o     (edge_count_o),
    .new_edge_o       (new_edge_o),
    .table_full_o     (table_full_o),
    .distinct_edges_o (distinct_edges_o),
    .total_events_o   (total_events_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // address whose edge from prev hashes to the given home slot; upper bits random
  function automatic logic [AddrWidth-1:0] chain_address(logic [AddrWidth-1:0] prev,
                                                         int unsigned home);
    logic [9:0] low;
    low = 10'((home + TableEntries - prev[9:0]) * InvHashMult);
    return {22'($urandom), low};
  endfunction

  function automatic logic [AddrWidth-1:0] pick_address();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic func, input logic [AddrWidth-1:0] addr);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    exec_address_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_input(func, addr);
    if (func == epct_pkg::FuncRecord) stim_prev = addr;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (ledger.outstanding() != 0);
  endtask

  initial begin : receiver_stall
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst != 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : result_monitor
    edge_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.edge_count     = edge_count_o;
        got.new_edge       = new_edge_o;
        got.table_full     = table_full_o;
        got.distinct_edges = distinct_edges_o;
        got.total_events   = total_events_o;
        ledger.check_result(got);
      end
    end
  end

  initial begin : stimulus
    logic [AddrWidth-1:0] loop_set [6];
    int unsigned          set_size;
    int unsigned          run_len;
    int unsigned          home;
    int unsigned          pick;
    bit                   held_once;
    held_once = 1'b0;
    ledger = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // address extremes, repeated edges, clear keeps the previous address
    send_item(epct_pkg::FuncRecord, '0);
    send_item(epct_pkg::FuncRecord, '0);
    send_item(epct_pkg::FuncRecord, '1);
    send_item(epct_pkg::FuncRecord, '1);
    send_item(epct_pkg::FuncRecord, '1);
    send_item(epct_pkg::FuncRecord, '0);
    send_item(epct_pkg::FuncRecord, '1);
    send_item(epct_pkg::FuncClear, '1);
    send_item(epct_pkg::FuncRecord, '0);
    send_item(epct_pkg::FuncClear, '0);
    // edges chained onto the last slot: wraps to the table start, then probes run out
    repeat (11) send_item(epct_pkg::FuncRecord, chain_address(stim_prev, TableEntries - 1));
    drain();

    // fill every slot in order, then records that find the table full
    send_item(epct_pkg::FuncClear, $urandom);
    for (int h = 0; h < TableEntries; h++) begin
      send_item(epct_pkg::FuncRecord, chain_address(stim_prev, h));
    end
    repeat (3) send_item(epct_pkg::FuncRecord, $urandom);
    drain();
    send_item(epct_pkg::FuncClear, $urandom);

    while (items_sent < TotalItems) begin
      calm = items_sent >= CalmAfter;
      if (!held_once && items_sent >= 1300) begin
        hold_cycles = 300;
        held_once   = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        // short loop over a few blocks: edges repeat and counts climb
        set_size = $urandom_range(1, 6);
        for (int i = 0; i < set_size; i++) loop_set[i] = pick_address();
        run_len = $urandom_range(8, 40);
        repeat (run_len) begin
          send_item(epct_pkg::FuncRecord, loop_set[$urandom_range(0, set_size - 1)]);
        end
      end else if (pick < 83) begin
        home    = $urandom_range(0, TableEntries - 1);
        run_len = $urandom_range(6, 12);
        repeat (run_len) send_item(epct_pkg::FuncRecord, chain_address(stim_prev, home));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 10)) send_item(epct_pkg::FuncRecord, pick_address());
      end else begin
        send_item(epct_pkg::FuncClear, $urandom);
      end
    end

    drain();
    repeat (64) @(negedge clk_i);
    if (ledger.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* edge_pair_count_table_core.f */
rtl/epct_pkg.sv
rtl/epct_front.sv
rtl/epct_queue.sv
rtl/epct_back.sv
rtl/edge_pair_count_table_core.sv
rtl/epct_checker.sv
tb/sv/tb_edge_pair_count_table_core.sv
